### sv/qbg_pkg.sv
// qbg_pkg: shared widths, angle constants, arctangent table and pipeline
// record types for the quaternion body-to-global unit.
// No dependencies.
`default_nettype none
package qbg_pkg;

  // Field widths
  localparam int QW = 16;   // quaternion component, Q2.14
  localparam int BW = 24;   // body / global vector, Q12.12
  localparam int HW = 16;   // heading, Q3.13

  // Internal widths
  localparam int PW  = 32;  // quaternion products, Q.28
  localparam int RW  = 34;  // matrix entries and yaw operands, Q.28
  localparam int MW  = RW + BW;  // matrix entry times body component
  localparam int SW  = MW + 2;   // dot product sum with rounding
  localparam int CW  = 36;  // CORDIC x / y
  localparam int ZW  = 34;  // CORDIC angle, Q.29 radians
  localparam int AW  = 37;  // angle plus heading and wrap

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  localparam logic signed [AW-1:0] ANG_PI     = 37'sd1686629713;
  localparam logic signed [AW-1:0] ANG_TWO_PI = 37'sd3373259426;

  // round(atan(2^-i) * 2^29)
  function automatic logic signed [ZW-1:0] atan_at(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 34'sd421657428;
      1:  v = 34'sd248918915;
      2:  v = 34'sd131521918;
      3:  v = 34'sd66762579;
      4:  v = 34'sd33510843;
      5:  v = 34'sd16771758;
      6:  v = 34'sd8387925;
      7:  v = 34'sd4194219;
      8:  v = 34'sd2097141;
      9:  v = 34'sd1048575;
      10: v = 34'sd524288;
      11: v = 34'sd262144;
      12: v = 34'sd131072;
      13: v = 34'sd65536;
      14: v = 34'sd32768;
      15: v = 34'sd16384;
      16: v = 34'sd8192;
      17: v = 34'sd4096;
      18: v = 34'sd2048;
      19: v = 34'sd1024;
      20: v = 34'sd512;
      21: v = 34'sd256;
      22: v = 34'sd128;
      23: v = 34'sd64;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Vector and angle handed from cell to cell
  typedef struct packed {
    logic                 vld;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // Rotation result plus side data riding along the CORDIC chain
  typedef struct packed {
    logic signed [BW-1:0] gx;
    logic signed [BW-1:0] gy;
    logic                 sat;
    logic signed [HW-1:0] hd;
    logic                 zero;
  } rot_t;

endpackage
`default_nettype wire

### sv/qbg_cordic_cell.sv
// qbg_cordic_cell: one vectoring CORDIC micro-rotation with its register.
// Depends on qbg_pkg.
`default_nettype none
module qbg_cordic_cell
  import qbg_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cordic_t cell_i,
  output cordic_t      cell_o
);

  logic                 vld_q;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic signed [CW-1:0] dx, dy;

  // Rotate toward the x axis, sign of y picks the direction
  always_comb begin
    dx = cell_i.y >>> STAGE;
    dy = cell_i.x >>> STAGE;
    if (!cell_i.y[CW-1]) begin
      x_d = cell_i.x + dx;
      y_d = cell_i.y - dy;
      z_d = cell_i.z + atan_at(STAGE);
    end else begin
      x_d = cell_i.x - dx;
      y_d = cell_i.y + dy;
      z_d = cell_i.z - atan_at(STAGE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign cell_o = '{vld: vld_q, x: x_q, y: y_q, z: z_q};

endmodule
`default_nettype wire

### sv/qbg_front.sv
// qbg_front: quaternion products, rotation matrix, body vector rotation with
// rounding and saturation, and the CORDIC quadrant pre-stage. Depends on qbg_pkg.
`default_nettype none
module qbg_front
  import qbg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 vld_i,
  input  wire logic signed [QW-1:0] quat_w_i,
  input  wire logic signed [QW-1:0] quat_x_i,
  input  wire logic signed [QW-1:0] quat_y_i,
  input  wire logic signed [QW-1:0] quat_z_i,
  input  wire logic signed [BW-1:0] body_x_i,
  input  wire logic signed [BW-1:0] body_y_i,
  input  wire logic signed [BW-1:0] body_z_i,
  input  wire logic signed [HW-1:0] heading_i,
  output cordic_t                   cordic_o,  // valid in the cycle before rot_o
  output rot_t                      rot_o
);

  localparam logic signed [RW-1:0] ONE_Q28   = RW'(64'sd1 <<< 28);
  localparam logic signed [SW-1:0] HALF_Q28  = SW'(64'sd1 <<< 27);
  localparam logic signed [SW-29:0] GMAX     = (SW-28)'(64'sd8388607);
  localparam logic signed [SW-29:0] GMIN     = -(SW-28)'(64'sd8388608);

  // Stage 1: quaternion products
  logic                 v1_q;
  logic signed [PW-1:0] p_ww_q, p_xx_q, p_yy_q, p_zz_q, p_xy_q;
  logic signed [PW-1:0] p_wz_q, p_xz_q, p_wy_q, p_yz_q, p_wx_q;
  logic signed [BW-1:0] bx1_q, by1_q, bz1_q;
  logic signed [HW-1:0] hd1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_ww_q <= PW'(quat_w_i * quat_w_i);
    p_xx_q <= PW'(quat_x_i * quat_x_i);
    p_yy_q <= PW'(quat_y_i * quat_y_i);
    p_zz_q <= PW'(quat_z_i * quat_z_i);
    p_xy_q <= PW'(quat_x_i * quat_y_i);
    p_wz_q <= PW'(quat_w_i * quat_z_i);
    p_xz_q <= PW'(quat_x_i * quat_z_i);
    p_wy_q <= PW'(quat_w_i * quat_y_i);
    p_yz_q <= PW'(quat_y_i * quat_z_i);
    p_wx_q <= PW'(quat_w_i * quat_x_i);
    bx1_q  <= body_x_i;
    by1_q  <= body_y_i;
    bz1_q  <= body_z_i;
    hd1_q  <= heading_i;
  end

  // Stage 2: matrix entries and yaw operands
  logic                 v2_q;
  logic signed [RW-1:0] r00_q, r01_q, r02_q, r10_q, r11_q, r12_q, yx_q;
  logic signed [RW-1:0] r00_d, r01_d, r02_d, r10_d, r11_d, r12_d, yx_d;
  logic signed [BW-1:0] bx2_q, by2_q, bz2_q;
  logic signed [HW-1:0] hd2_q;

  always_comb begin
    r00_d = RW'(p_ww_q) + RW'(p_xx_q) - RW'(p_yy_q) - RW'(p_zz_q);
    r11_d = RW'(p_ww_q) - RW'(p_xx_q) + RW'(p_yy_q) - RW'(p_zz_q);
    r01_d = (RW'(p_xy_q) - RW'(p_wz_q)) <<< 1;
    r02_d = (RW'(p_xz_q) + RW'(p_wy_q)) <<< 1;
    r10_d = (RW'(p_xy_q) + RW'(p_wz_q)) <<< 1;
    r12_d = (RW'(p_yz_q) - RW'(p_wx_q)) <<< 1;
    yx_d  = ((RW'(p_ww_q) + RW'(p_xx_q)) <<< 1) - ONE_Q28;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r00_q <= r00_d;
    r01_q <= r01_d;
    r02_q <= r02_d;
    r10_q <= r10_d;
    r11_q <= r11_d;
    r12_q <= r12_d;
    yx_q  <= yx_d;
    bx2_q <= bx1_q;
    by2_q <= by1_q;
    bz2_q <= bz1_q;
    hd2_q <= hd1_q;
  end

  // Stage 3: matrix times vector products; CORDIC quadrant fold
  // (yaw y operand equals r10)
  logic signed [MW-1:0] m00_q, m01_q, m02_q, m10_q, m11_q, m12_q;
  logic signed [HW-1:0] hd3_q;
  logic                 zero3_q, zero_d;
  logic                 pre_vld_q;
  logic signed [CW-1:0] pre_x_q, pre_y_q;
  logic signed [ZW-1:0] pre_z_q;
  cordic_t              pre_d;

  always_comb begin
    zero_d    = (yx_q == '0) && (r10_q == '0);
    pre_d.vld = v2_q;
    if (yx_q[RW-1]) begin
      pre_d.x = -CW'(yx_q);
      pre_d.y = -CW'(r10_q);
      pre_d.z = r10_q[RW-1] ? -ZW'(ANG_PI) : ZW'(ANG_PI);
    end else begin
      pre_d.x = CW'(yx_q);
      pre_d.y = CW'(r10_q);
      pre_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else begin
      pre_vld_q <= pre_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_x_q <= pre_d.x;
    pre_y_q <= pre_d.y;
    pre_z_q <= pre_d.z;
    m00_q   <= MW'(r00_q * bx2_q);
    m01_q   <= MW'(r01_q * by2_q);
    m02_q   <= MW'(r02_q * bz2_q);
    m10_q   <= MW'(r10_q * bx2_q);
    m11_q   <= MW'(r11_q * by2_q);
    m12_q   <= MW'(r12_q * bz2_q);
    hd3_q   <= hd2_q;
    zero3_q <= zero_d;
  end

  // Stage 4: sum, round half up to Q.12, saturate
  logic signed [SW-1:0]  sx, sy;
  logic signed [SW-29:0] fx, fy;
  rot_t                  rot_d, rot_q;

  always_comb begin
    sx = SW'(m00_q) + SW'(m01_q) + SW'(m02_q) + HALF_Q28;
    sy = SW'(m10_q) + SW'(m11_q) + SW'(m12_q) + HALF_Q28;
    fx = (SW-28)'(sx >>> 28);
    fy = (SW-28)'(sy >>> 28);
    rot_d.sat = 1'b0;
    if (fx > GMAX) begin
      rot_d.gx = BW'(GMAX);
      rot_d.sat = 1'b1;
    end else if (fx < GMIN) begin
      rot_d.gx = BW'(GMIN);
      rot_d.sat = 1'b1;
    end else begin
      rot_d.gx = BW'(fx);
    end
    if (fy > GMAX) begin
      rot_d.gy = BW'(GMAX);
      rot_d.sat = 1'b1;
    end else if (fy < GMIN) begin
      rot_d.gy = BW'(GMIN);
      rot_d.sat = 1'b1;
    end else begin
      rot_d.gy = BW'(fy);
    end
    rot_d.hd   = hd3_q;
    rot_d.zero = zero3_q;
  end

  always_ff @(posedge clk_i) begin
    rot_q <= rot_d;
  end

  assign cordic_o = '{vld: pre_vld_q, x: pre_x_q, y: pre_y_q, z: pre_z_q};
  assign rot_o    = rot_q;

endmodule
`default_nettype wire

### sv/quaternion_body_to_global_unit.sv
// quaternion_body_to_global_unit: top level, front pipeline, CORDIC cell
// chain, delay line and heading output stage. Depends on qbg_pkg,
// qbg_front and qbg_cordic_cell.
//
// Fully pipelined: a transaction is taken on every cycle start is high (busy
// is tied low) and its result appears on result_valid_o once it has passed
// the front stages, the CORDIC cell chain and the output register. The
// CORDIC cell chain, one micro-rotation per cell, is the longest path; the
// matrix rotation finishes early and waits in a delay line. Results cannot
// be stalled and must be taken on the strobe cycle.
`default_nettype none
module quaternion_body_to_global_unit
  import qbg_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [QW-1:0] quat_w_i,
  input  wire logic signed [QW-1:0] quat_x_i,
  input  wire logic signed [QW-1:0] quat_y_i,
  input  wire logic signed [QW-1:0] quat_z_i,
  input  wire logic signed [BW-1:0] body_x_i,
  input  wire logic signed [BW-1:0] body_y_i,
  input  wire logic signed [BW-1:0] body_z_i,
  input  wire logic signed [HW-1:0] heading_in_i,
  output logic                      result_valid_o,
  output logic signed [BW-1:0]      global_x_o,
  output logic signed [BW-1:0]      global_y_o,
  output logic signed [HW-1:0]      global_heading_o,
  output logic                      saturated_o
);

  localparam logic signed [AW-1:0] HALF_Q16 = AW'(64'sd32768);
  localparam logic signed [AW-17:0] HMAX    = (AW-16)'(64'sd32767);
  localparam logic signed [AW-17:0] HMIN    = -(AW-16)'(64'sd32768);

  assign busy = 1'b0;

  // Front pipeline
  cordic_t pre;
  rot_t    rot;

  qbg_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (start & ~busy),
    .quat_w_i  (quat_w_i),
    .quat_x_i  (quat_x_i),
    .quat_y_i  (quat_y_i),
    .quat_z_i  (quat_z_i),
    .body_x_i  (body_x_i),
    .body_y_i  (body_y_i),
    .body_z_i  (body_z_i),
    .heading_i (heading_in_i),
    .cordic_o  (pre),
    .rot_o     (rot)
  );

  // CORDIC cell chain
  cordic_t chain [CORDIC_STAGES+1];
  assign chain[0] = pre;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    qbg_cordic_cell #(.STAGE(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // Delay line aligning the rotation result with the chain end
  rot_t dly_q [CORDIC_STAGES-1];

  always_ff @(posedge clk_i) begin
    dly_q[0] <= rot;
    for (int k = 1; k < CORDIC_STAGES - 1; k++) begin
      dly_q[k] <= dly_q[k-1];
    end
  end

  rot_t    rot_al;
  cordic_t fin;
  assign rot_al = dly_q[CORDIC_STAGES-2];
  assign fin    = chain[CORDIC_STAGES];

  // Heading: add target, one wrap, round to Q3.13, saturate
  logic signed [AW-1:0]  ang, angw, angr;
  logic signed [AW-17:0] hq;
  logic signed [HW-1:0]  hdg_d;

  always_comb begin
    ang = (rot_al.zero ? '0 : AW'(fin.z)) + (AW'(rot_al.hd) <<< 16);
    if (ang < -ANG_PI) begin
      angw = ang + ANG_TWO_PI;
    end else if (ang > ANG_PI) begin
      angw = ang - ANG_TWO_PI;
    end else begin
      angw = ang;
    end
    angr = angw + HALF_Q16;
    hq   = (AW-16)'(angr >>> 16);
    if (hq > HMAX) begin
      hdg_d = HW'(HMAX);
    end else if (hq < HMIN) begin
      hdg_d = HW'(HMIN);
    end else begin
      hdg_d = HW'(hq);
    end
  end

  // Output register
  logic                 vld_q;
  logic signed [BW-1:0] gx_q, gy_q;
  logic signed [HW-1:0] hdg_q;
  logic                 sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= fin.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q  <= rot_al.gx;
    gy_q  <= rot_al.gy;
    hdg_q <= hdg_d;
    sat_q <= rot_al.sat;
  end

  assign result_valid_o   = vld_q;
  assign global_x_o       = gx_q;
  assign global_y_o       = gy_q;
  assign global_heading_o = hdg_q;
  assign saturated_o      = sat_q;

`ifndef NO_ASSERTIONS
  // A result only ever follows an accepted transaction by the full latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, CORDIC_STAGES + 4))
    else $error("result without matching transaction");

  // Saturation flag implies a clipped coordinate
  a_sat_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && saturated_o) |->
      (global_x_o == 24'sh7fffff || global_x_o == -24'sh800000 ||
       global_y_o == 24'sh7fffff || global_y_o == -24'sh800000))
    else $error("saturated set without clipped output");

  // Chain valid reaches the output register in the next cycle
  a_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.vld |=> result_valid_o)
    else $error("chain result lost at output");
`endif

endmodule
`default_nettype wire
